// File: hdl/rspe_pkg.sv
// ---------------------------------------------------------------------------
// rspe_pkg
// Shared constants and GF(256) arithmetic for the Reed-Solomon parity encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

  localparam int MAX_PARITY_DEFAULT = 32;
  localparam int PARITY_RESET       = 10;
  localparam int CFG_WIDTH          = 6;
  localparam int BYTE_WIDTH         = 8;

  localparam logic [7:0] GF_POLY_LOW = 8'h1D;
  localparam logic [7:0] GF_TOP_BIT  = 8'h80;
  localparam logic [7:0] GF_ALPHA    = 8'h02;
  localparam logic [7:0] GF_ONE      = 8'h01;

  // product of two field elements, modulo x^8 + x^4 + x^3 + x^2 + 1
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x   = a;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      if ((x & GF_TOP_BIT) != 8'h00) begin
        x = {x[6:0], 1'b0} ^ GF_POLY_LOW;
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rspe_gen.sv
// ---------------------------------------------------------------------------
// rspe_gen
// Generator polynomial builder: multiplies in one root per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rspe_gen #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEFAULT,
  parameter int CW         = $clog2(MAX_PARITY + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            rebuild,
  input  wire logic [CW-1:0]                   count,
  output logic                                 busy,
  output logic [MAX_PARITY-1:0][7:0]           coef
);

  logic [7:0]    poly      [0:MAX_PARITY];
  logic [7:0]    poly_next [0:MAX_PARITY];
  logic [7:0]    root;
  logic [CW-1:0] step;

  always_comb begin
    for (int j = 0; j < MAX_PARITY; j++) begin
      poly_next[j] = poly[j + 1] ^ rspe_pkg::gf_mul(poly[j], root);
    end
    poly_next[MAX_PARITY] = rspe_pkg::gf_mul(poly[MAX_PARITY], root);
    for (int j = 0; j < MAX_PARITY; j++) begin
      coef[j] = poly[j + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (rebuild) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == count) begin
        busy <= 1'b0;
      end else begin
        step <= step + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rebuild) begin
      root <= rspe_pkg::GF_ONE;
      for (int j = 0; j <= MAX_PARITY; j++) begin
        poly[j] <= (j == int'(count)) ? rspe_pkg::GF_ONE : 8'h00;
      end
    end else if (busy && (step != count)) begin
      root <= rspe_pkg::gf_mul(root, rspe_pkg::GF_ALPHA);
      for (int j = 0; j <= MAX_PARITY; j++) begin
        poly[j] <= poly_next[j];
      end
    end
  end

  a_rebuild_starts: assert property (@(posedge clk) disable iff (rst)
    rebuild |=> busy && (step == '0))
    else $error("rebuild did not restart the generator");

endmodule

`default_nettype wire

// File: hdl/rspe_lfsr.sv
// ---------------------------------------------------------------------------
// rspe_lfsr
// Input register and division register; hands the parity to the drain stage.
// ---------------------------------------------------------------------------
`default_nettype none

module rspe_lfsr #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            hold,
  input  wire logic                            clear,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_data,
  input  wire logic                            in_last,
  input  wire logic [MAX_PARITY-1:0][7:0]      coef,
  input  wire logic                            free,
  output logic                                 load,
  output logic [MAX_PARITY-1:0][7:0]           snap
);

  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       advance;
  logic [7:0] fb;
  logic [7:0] preg [0:MAX_PARITY-1];

  always_comb begin
    fb = s1_data ^ preg[0];
    for (int j = 0; j < MAX_PARITY - 1; j++) begin
      snap[j] = preg[j + 1] ^ rspe_pkg::gf_mul(fb, coef[j]);
    end
    snap[MAX_PARITY-1] = rspe_pkg::gf_mul(fb, coef[MAX_PARITY-1]);
  end

  assign advance  = s1_valid && !hold && (!s1_last || free);
  assign in_ready = !hold && (!s1_valid || advance);
  assign load     = advance && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear || load) begin
      for (int j = 0; j < MAX_PARITY; j++) begin
        preg[j] <= 8'h00;
      end
    end else if (advance) begin
      for (int j = 0; j < MAX_PARITY; j++) begin
        preg[j] <= snap[j];
      end
    end
  end

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && !free && !hold |=> s1_valid && s1_last)
    else $error("final byte left the input register without a free buffer");

  a_cleared_after_last: assert property (@(posedge clk) disable iff (rst)
    load |=> (preg[0] == 8'h00))
    else $error("division register not cleared after block end");

endmodule

`default_nettype wire

// File: hdl/rspe_drain.sv
// ---------------------------------------------------------------------------
// rspe_drain
// Parity output buffer: shifts out one parity byte per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module rspe_drain #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEFAULT,
  parameter int CW         = $clog2(MAX_PARITY + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire logic [MAX_PARITY-1:0][7:0]      snap,
  input  wire logic [CW-1:0]                   count,
  output logic                                 free,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_data,
  output logic                                 out_last
);

  logic [7:0]    pbuf [0:MAX_PARITY-1];
  logic [CW-1:0] cnt;
  logic          xfer;

  assign out_valid = (cnt != '0);
  assign out_last  = (cnt == CW'(1));
  assign out_data  = pbuf[0];
  assign xfer      = out_valid && out_ready;
  assign free      = (cnt == '0) || (out_last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= count;
    end else if (xfer) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < MAX_PARITY; j++) begin
        pbuf[j] <= snap[j];
      end
    end else if (xfer) begin
      for (int j = 0; j < MAX_PARITY - 1; j++) begin
        pbuf[j] <= pbuf[j + 1];
      end
      pbuf[MAX_PARITY-1] <= 8'h00;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("parity buffer overwritten while draining");

  a_drain_steps: assert property (@(posedge clk) disable iff (rst)
    xfer && !load |=> (cnt == $past(cnt) - CW'(1)))
    else $error("parity count did not advance on transfer");

endmodule

`default_nettype wire

// File: hdl/reed_solomon_parity_encoder_top.sv
// ---------------------------------------------------------------------------
// reed_solomon_parity_encoder_top
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
//
// Data bytes enter on the s_axis stream, one per transfer; tlast marks the
// final byte of a block. After the final byte the block sends parity_count
// parity bytes on the m_axis stream, highest order first, tlast on the last.
// The final data byte passes from the input register through the division
// step into the parity buffer, and the first parity byte is then valid. Data
// bytes are taken at one per cycle, also while the parity of the previous
// block drains; a final byte waits in the input register until the parity
// buffer is free, and s_axis_tready is low meanwhile.
// The cfg channel writes parity_count (0 reads as 1, values above MAX_PARITY
// are clamped). After reset and after each write the generator polynomial is
// rebuilt, one root per cycle; s_axis_tready is low during the write and the
// rebuild, and a write also clears the division register.
// Reset sets parity_count to 10. A stalled receiver holds the parity bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder_top #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rspe_pkg::CFG_WIDTH-1:0]    cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [rspe_pkg::BYTE_WIDTH-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [rspe_pkg::BYTE_WIDTH-1:0]        m_axis_tdata,   // [7:0] parity_byte
  output logic                                   m_axis_tlast
);

  localparam int CW        = $clog2(MAX_PARITY + 1);
  localparam int RST_COUNT = (rspe_pkg::PARITY_RESET > MAX_PARITY) ?
                             MAX_PARITY : rspe_pkg::PARITY_RESET;

  logic                         cfg_write;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic                         rebuild;
  logic                         gen_busy;
  logic [MAX_PARITY-1:0][7:0]   coef;
  logic [MAX_PARITY-1:0][7:0]   snap;
  logic                         load;
  logic                         free;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    if (32'(cfg_data) > MAX_PARITY) begin
      count_next = CW'(MAX_PARITY);
    end else if (cfg_data == '0) begin
      count_next = CW'(1);
    end else begin
      count_next = CW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= CW'(RST_COUNT);
      rebuild <= 1'b1;
    end else begin
      rebuild <= cfg_write;
      if (cfg_write) begin
        count <= count_next;
      end
    end
  end

  rspe_gen #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_gen (
    .clk     (clk),
    .rst     (rst),
    .rebuild (rebuild),
    .count   (count),
    .busy    (gen_busy),
    .coef    (coef)
  );

  rspe_lfsr #(
    .MAX_PARITY (MAX_PARITY)
  ) u_lfsr (
    .clk      (clk),
    .rst      (rst),
    .hold     (gen_busy || rebuild || cfg_write),
    .clear    (cfg_write),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .coef     (coef),
    .free     (free),
    .load     (load),
    .snap     (snap)
  );

  rspe_drain #(
    .MAX_PARITY (MAX_PARITY),
    .CW         (CW)
  ) u_drain (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .snap      (snap),
    .count     (count),
    .free      (free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: test/reed_solomon_parity_encoder_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reed_solomon_parity_encoder_top_test
// Self-checking bench for the GF(256) Reed-Solomon parity encoder.
//
// Data bytes go in on s_axis, parity bytes come back on m_axis. A local
// encoder built on log/antilog tables tracks the division register and the
// generator for the current parity count, and queues the parity expected
// for each block. A short table of directed transfers runs first, then
// random blocks under three idling patterns. parity_count is rewritten
// between blocks, and now and then in the middle of one, over its full range.
// ---------------------------------------------------------------------------

module reed_solomon_parity_encoder_top_test;

  localparam int MAX_PAR     = rspe_pkg::MAX_PARITY_DEFAULT;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } parity_due_t;

  typedef struct packed {
    logic                         is_cfg;
    logic [rspe_pkg::CFG_WIDTH-1:0] cfg;
    logic [7:0]                   data;
    logic                         last;
    logic                         typed;
    logic [7:0]                   typed_val;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [rspe_pkg::CFG_WIDTH-1:0]    cfg_data = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [rspe_pkg::BYTE_WIDTH-1:0]   s_axis_tdata = '0;   // [7:0] data_byte
  logic                              s_axis_tlast = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [rspe_pkg::BYTE_WIDTH-1:0]   m_axis_tdata;        // [7:0] parity_byte
  logic                              m_axis_tlast;

  logic [7:0]  gf_exp [0:254];
  int          gf_log [0:255];
  logic [7:0]  encoder_taps [0:MAX_PAR-1];
  logic [7:0]  gen_coeff [0:MAX_PAR-1];
  int          active_count;
  parity_due_t parity_due [$];
  int          err_count = 0;
  int          src_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          quiet_cycles = 0;

  // zero block after reset, XOR parity at count 1, count extremes, mid-block write
  stim_row_t directed_rows [0:22] = '{
    '{1'b0, 6'd0,  8'h00, 1'b1, 1'b1, 8'h00},
    '{1'b0, 6'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h80, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h01, 1'b1, 1'b0, 8'h00},
    '{1'b1, 6'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'hFF, 1'b1, 1'b1, 8'hFF},
    '{1'b0, 6'd0,  8'h55, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'hAA, 1'b1, 1'b1, 8'hFF},
    '{1'b1, 6'd63, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'hFF, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h7F, 1'b1, 1'b0, 8'h00},
    '{1'b1, 6'd32, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h80, 1'b1, 1'b0, 8'h00},
    '{1'b1, 6'd33, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h01, 1'b1, 1'b0, 8'h00},
    '{1'b1, 6'd2,  8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h12, 1'b0, 1'b0, 8'h00},
    '{1'b1, 6'd10, 8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'h34, 1'b1, 1'b0, 8'h00},
    '{1'b1, 6'd1,  8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, 6'd0,  8'hC3, 1'b1, 1'b1, 8'hC3},
    '{1'b0, 6'd0,  8'h00, 1'b1, 1'b1, 8'h00}
  };

  reed_solomon_parity_encoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
    int sum;
    if (a == 8'h00 || b == 8'h00) begin
      return 8'h00;
    end
    sum = gf_log[a] + gf_log[b];
    if (sum >= 255) begin
      sum -= 255;
    end
    return gf_exp[sum];
  endfunction

  task automatic note_error(input string what);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
  endtask

  // clamp the count, clear the division register, rebuild the generator
  task automatic set_parity_count(input logic [rspe_pkg::CFG_WIDTH-1:0] v);
    int n;
    logic [7:0] c [0:MAX_PAR];
    logic [7:0] root;
    n = v;
    if (n < 1) begin
      n = 1;
    end
    if (n > MAX_PAR) begin
      n = MAX_PAR;
    end
    active_count = n;
    foreach (c[k]) c[k] = 8'h00;
    c[0] = 8'h01;
    root = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k >= 1; k--) begin
        c[k] = c[k-1] ^ gf_product(c[k], root);
      end
      c[0] = gf_product(c[0], root);
      root = gf_product(root, 8'h02);
    end
    for (int j = 0; j < MAX_PAR; j++) begin
      encoder_taps[j] = 8'h00;
      gen_coeff[j] = (j < n) ? c[n-1-j] : 8'h00;
    end
  endtask

  task automatic encode_byte(input logic [7:0] d, input logic l, input logic typed,
                             input logic [7:0] tv);
    logic [7:0] fb;
    fb = d ^ encoder_taps[0];
    for (int j = 0; j < active_count - 1; j++) begin
      encoder_taps[j] = encoder_taps[j+1] ^ gf_product(fb, gen_coeff[j]);
    end
    encoder_taps[active_count-1] = gf_product(fb, gen_coeff[active_count-1]);
    if (l) begin
      for (int j = 0; j < active_count; j++) begin
        parity_due.push_back('{typed ? tv : encoder_taps[j], j == active_count - 1});
        encoder_taps[j] = 8'h00;
      end
    end
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                           input logic [7:0] tv);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    encode_byte(d, l, typed, tv);
    @(negedge clk);
  endtask

  task automatic drain_parity();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (parity_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(input logic [rspe_pkg::CFG_WIDTH-1:0] v);
    drain_parity();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_parity_count(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [rspe_pkg::CFG_WIDTH-1:0] pick_count();
    case ($urandom_range(9))
      0:       return 6'd0;
      1:       return 6'd63;
      2:       return 6'd32;
      3:       return 6'($urandom_range(33, 63));
      4:       return 6'($urandom_range(63));
      default: return 6'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic run_phase(input int src_pct, input int rcv_pct, input int n_items);
    int sent;
    int blen;
    src_idle_pct = src_pct;
    rcv_idle_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        write_count(pick_count());
      end
      blen = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 5);
      for (int k = 0; k < blen; k++) begin
        send_byte(8'($urandom_range(255)), k == blen - 1, 1'b0, 8'h00);
        if (k == 0 && blen > 1 && $urandom_range(11) == 0) begin
          write_count(pick_count());
        end
      end
      sent += blen;
      if ($urandom_range(7) == 0) begin
        drain_parity();
      end
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin : check_parity
    parity_due_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (parity_due.size() == 0) begin
        note_error($sformatf("unexpected parity byte %02h last %0b",
                             m_axis_tdata, m_axis_tlast));
      end else begin
        due = parity_due.pop_front();
        if (m_axis_tdata !== due.value || m_axis_tlast !== due.last) begin
          note_error($sformatf("parity expected %02h last %0b, got %02h last %0b",
                               due.value, due.last, m_axis_tdata, m_axis_tlast));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("** reed_solomon_parity_encoder_top: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [8:0] walk;
    walk = 9'h001;
    for (int i = 0; i < 255; i++) begin
      gf_exp[i] = walk[7:0];
      gf_log[walk[7:0]] = i;
      walk = walk << 1;
      if (walk[8]) begin
        walk ^= 9'h11D;
      end
    end
    gf_log[0] = 0;
    set_parity_count(6'(rspe_pkg::PARITY_RESET));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        write_count(directed_rows[r].cfg);
      end else begin
        send_byte(directed_rows[r].data, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].typed_val);
      end
    end

    run_phase(9, 51, 104);
    run_phase(51, 9, 103);
    run_phase(0, 0, 103);

    drain_parity();
    repeat (20) @(negedge clk);
    if (parity_due.size() != 0) begin
      note_error($sformatf("%0d parity bytes never arrived", parity_due.size()));
    end
    if (err_count == 0) begin
      $display("** reed_solomon_parity_encoder_top: PASSED **");
    end else begin
      $display("** reed_solomon_parity_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule
